@@ src/rlu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial lens undistort package
// Shared payload types, register codes, pipeline latencies and the saturating
// helpers of the correction datapath.
// ----------------------------------------------------------------------------
package rlu_pkg;

  // Input beat: one distorted point, signed Q16.16.
  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
  } in_t;

  // Result beat: corrected point and pass-through flag.
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               unchanged;
  } out_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_COEF_R1  = 3'd2,
    REG_COEF_R3  = 3'd3,
    REG_COEF_R5  = 3'd4,
    REG_COEF_R7  = 3'd5
  } cfg_reg_t;

  // Unit latencies.
  localparam int MUL_LAT    = 3;   // 64x64 multiplier from four 32x32 products
  localparam int SQRT_STEPS = 32;  // one root bit per stage
  localparam int QBITS      = 62;  // one quotient bit per stage

  // Cycles from an accepted beat to its result strobe.
  localparam int LATENCY = 4 + SQRT_STEPS + 4 * (MUL_LAT + 1) + (MUL_LAT + 1) + 3 + 1
                           + MUL_LAT + QBITS + 1;

  localparam logic signed [63:0] CAP62 = 64'sh3FFF_FFFF_FFFF_FFFF;

  // Saturate an unsigned product (already shifted) at 2^62-1.
  function automatic logic [61:0] sat62(input logic [127:0] v);
    if (|v[127:62]) begin
      return {62{1'b1}};
    end
    return v[61:0];
  endfunction

  // Clamp a signed sum to +-(2^62-1).
  function automatic logic signed [63:0] clamp62(input logic signed [63:0] v);
    if (v > CAP62) begin
      return CAP62;
    end else if (v < -CAP62) begin
      return -CAP62;
    end
    return v;
  endfunction

  // Clamp a wide signed value to the 32-bit signed range.
  function automatic logic [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

@@ src/rlu_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined 64x64 unsigned multiplier
// Four 32x32 partial products, then the cross terms, then the final add.
// ----------------------------------------------------------------------------
module rlu_mul
  import rlu_pkg::*;
(
  input  logic         clk,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] p
);

  logic [63:0]  p00, p01, p10, p11;
  logic [64:0]  mid;
  logic [127:0] outer;

  // Partial products.
  always_ff @(posedge clk) begin
    p00 <= a[31:0] * b[31:0];
    p01 <= a[31:0] * b[63:32];
    p10 <= a[63:32] * b[31:0];
    p11 <= a[63:32] * b[63:32];
  end

  // Cross terms summed, outer terms packed.
  always_ff @(posedge clk) begin
    mid   <= {1'b0, p01} + {1'b0, p10};
    outer <= {p11, p00};
  end

  // Final accumulation.
  always_ff @(posedge clk) begin
    p <= outer + {31'b0, mid, 32'b0};
  end

endmodule

@@ src/rlu_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor square root of a 64-bit value, one root bit a stage.
// ----------------------------------------------------------------------------
module rlu_isqrt
  import rlu_pkg::*;
(
  input  logic        clk,
  input  logic [63:0] n,
  output logic [31:0] root
);

  logic [63:0] n_q    [SQRT_STEPS];
  logic [35:0] rem_q  [SQRT_STEPS];
  logic [31:0] root_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [63:0] n_in;
    logic [35:0] rem_in;
    logic [31:0] root_in;
    logic [35:0] cur;
    logic [35:0] trial;

    if (k == 0) begin : g_first
      assign n_in    = n;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign n_in    = n_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // Bring down the next two bits and try the next root bit.
    assign cur   = {rem_in[33:0], n_in[2*(SQRT_STEPS-1-k)+1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      n_q[k] <= n_in;
      if (cur >= trial) begin
        rem_q[k]  <= cur - trial;
        root_q[k] <= {root_in[30:0], 1'b1};
      end else begin
        rem_q[k]  <= cur;
        root_q[k] <= {root_in[30:0], 1'b0};
      end
    end
  end

  assign root = root_q[SQRT_STEPS-1];

endmodule

@@ src/rlu_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Divides a 94-bit numerator by a 32-bit divisor, one quotient bit a stage.
// The quotient is known to fit 62 bits, so the top bits start the remainder.
// ----------------------------------------------------------------------------
module rlu_div
  import rlu_pkg::*;
(
  input  logic             clk,
  input  logic [93:0]      num,
  input  logic [31:0]      den,
  output logic [QBITS-1:0] quo
);

  logic [QBITS-1:0] num_q [QBITS];
  logic [31:0]      rem_q [QBITS];
  logic [31:0]      den_q [QBITS];
  logic [QBITS-1:0] quo_q [QBITS];

  for (genvar k = 0; k < QBITS; k++) begin : g_step
    logic [QBITS-1:0] num_in;
    logic [31:0]      rem_in;
    logic [31:0]      den_in;
    logic [QBITS-1:0] quo_in;
    logic [32:0]      cur;
    logic [32:0]      diff;

    if (k == 0) begin : g_first
      assign num_in = num[QBITS-1:0];
      assign rem_in = num[93:QBITS];
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // Shift in one numerator bit and subtract when it fits.
    assign cur  = {rem_in, num_in[QBITS-1-k]};
    assign diff = cur - {1'b0, den_in};

    always_ff @(posedge clk) begin
      num_q[k] <= num_in;
      den_q[k] <= den_in;
      if (cur >= {1'b0, den_in}) begin
        rem_q[k] <= diff[31:0];
        quo_q[k] <= {quo_in[QBITS-2:0], 1'b1};
      end else begin
        rem_q[k] <= cur[31:0];
        quo_q[k] <= {quo_in[QBITS-2:0], 1'b0};
      end
    end
  end

  assign quo = quo_q[QBITS-1];

endmodule

@@ src/radial_lens_undistort.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial lens undistort
// Moves a point toward the distortion center by an odd radial polynomial of
// its radius, or away if negative, with saturating fixed-point arithmetic throughout.
// ----------------------------------------------------------------------------
// Takes one point per clock outside reset and returns each result on a
// one-cycle done strobe; results cannot be held off. Most of the latency
// lies in the 32-stage square root and the 62-stage divider that scales the
// correction along the radius. busy is high only in reset. Configuration
// writes are ready outside reset and must be made while no point is
// in flight.
module radial_lens_undistort
  import rlu_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16,
  parameter int COEF_FRAC_BITS  = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         point,
  output logic        done,
  output out_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  // Stage numbers, counted from the accepting edge.
  localparam int T_DX   = 1;
  localparam int T_ABS  = 2;
  localparam int T_SQ   = 3;
  localparam int T_N    = 4;
  localparam int T_R    = T_N + SQRT_STEPS;
  localparam int T_S    = T_R + MUL_LAT + 1;
  localparam int T_P3   = T_S + MUL_LAT + 1;
  localparam int T_P5   = T_P3 + MUL_LAT + 1;
  localparam int T_P7   = T_P5 + MUL_LAT + 1;
  localparam int T_TERM = T_P7 + MUL_LAT + 1;
  localparam int T_SUM  = T_TERM + 3;
  localparam int T_AD   = T_SUM + 1;
  localparam int T_NUM  = T_AD + MUL_LAT;
  localparam int T_Q    = T_NUM + QBITS;
  localparam int T_OUT  = T_Q + 1;

  typedef struct packed {
    in_t                pt;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } side_t;

  typedef struct packed {
    logic unch;
    logic neg;
  } flag_t;

  // Configuration registers.
  logic signed [31:0] center_x, center_y;
  logic signed [47:0] coef_r1, coef_r3, coef_r5, coef_r7;

  assign cfg_ready = !rst;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      coef_r1  <= '0;
      coef_r3  <= '0;
      coef_r5  <= '0;
      coef_r7  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER_X: center_x <= cfg_data[31:0];
        REG_CENTER_Y: center_y <= cfg_data[31:0];
        REG_COEF_R1:  coef_r1  <= cfg_data;
        REG_COEF_R3:  coef_r3  <= cfg_data;
        REG_COEF_R5:  coef_r5  <= cfg_data;
        REG_COEF_R7:  coef_r7  <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [63:0] mag48(input logic signed [47:0] c);
    logic [47:0] m;
    m = c[47] ? 48'(-c) : 48'(c);
    return {16'b0, m};
  endfunction

  // Valid line.
  logic v_q [1:T_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= T_OUT; k++) v_q[k] <= 1'b0;
    end else begin
      v_q[1] <= start && !busy;
      for (int k = 2; k <= T_OUT; k++) v_q[k] <= v_q[k-1];
    end
  end

  // Offset from the center, saturated, and the pass-through sideband.
  side_t              side_q [T_DX:T_Q];
  logic signed [65:0] ddx, ddy;

  assign ddx = 66'(point.in_x) - 66'(center_x);
  assign ddy = 66'(point.in_y) - 66'(center_y);

  always_ff @(posedge clk) begin
    side_q[T_DX].pt <= point;
    side_q[T_DX].dx <= clamp32(ddx);
    side_q[T_DX].dy <= clamp32(ddy);
    for (int k = T_DX + 1; k <= T_Q; k++) side_q[k] <= side_q[k-1];
  end

  // Offset magnitudes.
  logic [31:0] ax_q [T_ABS:T_AD];
  logic [31:0] ay_q [T_ABS:T_AD];

  always_ff @(posedge clk) begin
    ax_q[T_ABS] <= side_q[T_DX].dx[31] ? 32'(-side_q[T_DX].dx) : 32'(side_q[T_DX].dx);
    ay_q[T_ABS] <= side_q[T_DX].dy[31] ? 32'(-side_q[T_DX].dy) : 32'(side_q[T_DX].dy);
    for (int k = T_ABS + 1; k <= T_AD; k++) begin
      ax_q[k] <= ax_q[k-1];
      ay_q[k] <= ay_q[k-1];
    end
  end

  // Squared radius.
  logic [63:0] sqx_q, sqy_q, n_q;

  always_ff @(posedge clk) begin
    sqx_q <= ax_q[T_ABS] * ax_q[T_ABS];
    sqy_q <= ay_q[T_ABS] * ay_q[T_ABS];
    n_q   <= sqx_q + sqy_q;
  end

  // Radius.
  logic [31:0] r_w;
  logic [31:0] r_q [T_R+1:T_NUM];

  rlu_isqrt u_isqrt (
    .clk  (clk),
    .n    (n_q),
    .root (r_w)
  );

  always_ff @(posedge clk) begin
    r_q[T_R+1] <= r_w;
    for (int k = T_R + 2; k <= T_NUM; k++) r_q[k] <= r_q[k-1];
  end

  // Squared radius and odd powers of the radius.
  logic [127:0] ms_w, m3_w, m5_w, m7_w;
  logic [61:0]  s_q  [T_S:T_P5];
  logic [61:0]  p3_q [T_P3:T_P7];
  logic [61:0]  p5_q [T_P5:T_P7];
  logic [61:0]  p7_q;

  rlu_mul u_mul_s (
    .clk (clk), .a ({32'b0, r_w}), .b ({32'b0, r_w}), .p (ms_w)
  );
  rlu_mul u_mul_p3 (
    .clk (clk), .a ({32'b0, r_q[T_S]}), .b ({2'b0, s_q[T_S]}), .p (m3_w)
  );
  rlu_mul u_mul_p5 (
    .clk (clk), .a ({2'b0, p3_q[T_P3]}), .b ({2'b0, s_q[T_P3]}), .p (m5_w)
  );
  rlu_mul u_mul_p7 (
    .clk (clk), .a ({2'b0, p5_q[T_P5]}), .b ({2'b0, s_q[T_P5]}), .p (m7_w)
  );

  always_ff @(posedge clk) begin
    s_q[T_S]   <= sat62(ms_w >> COORD_FRAC_BITS);
    p3_q[T_P3] <= sat62(m3_w >> COORD_FRAC_BITS);
    p5_q[T_P5] <= sat62(m5_w >> COORD_FRAC_BITS);
    p7_q       <= sat62(m7_w >> COORD_FRAC_BITS);
    for (int k = T_S + 1; k <= T_P5; k++) s_q[k] <= s_q[k-1];
    for (int k = T_P3 + 1; k <= T_P7; k++) p3_q[k] <= p3_q[k-1];
    for (int k = T_P5 + 1; k <= T_P7; k++) p5_q[k] <= p5_q[k-1];
  end

  // Polynomial terms, each signed by its coefficient.
  logic [127:0] mt1_w, mt3_w, mt5_w, mt7_w;
  logic signed [63:0] t1_q, t3_q, t5_q, t7_q;

  rlu_mul u_mul_t1 (
    .clk (clk), .a (mag48(coef_r1)), .b ({32'b0, r_q[T_P7]}), .p (mt1_w)
  );
  rlu_mul u_mul_t3 (
    .clk (clk), .a (mag48(coef_r3)), .b ({2'b0, p3_q[T_P7]}), .p (mt3_w)
  );
  rlu_mul u_mul_t5 (
    .clk (clk), .a (mag48(coef_r5)), .b ({2'b0, p5_q[T_P7]}), .p (mt5_w)
  );
  rlu_mul u_mul_t7 (
    .clk (clk), .a (mag48(coef_r7)), .b ({2'b0, p7_q}), .p (mt7_w)
  );

  function automatic logic signed [63:0] signed_term(input logic [127:0] prod,
                                                      input logic neg);
    logic [63:0] t;
    t = {2'b0, sat62(prod >> COEF_FRAC_BITS)};
    return neg ? -$signed(t) : $signed(t);
  endfunction

  always_ff @(posedge clk) begin
    t1_q <= signed_term(mt1_w, coef_r1[47]);
    t3_q <= signed_term(mt3_w, coef_r3[47]);
    t5_q <= signed_term(mt5_w, coef_r5[47]);
    t7_q <= signed_term(mt7_w, coef_r7[47]);
  end

  // Saturating sum, one addition a stage in term order.
  logic signed [63:0] sa_q, sb_q, sum_q, t5_d, t7_d, t7_dd;

  always_ff @(posedge clk) begin
    sa_q  <= clamp62(t1_q + t3_q);
    t5_d  <= t5_q;
    t7_d  <= t7_q;
    sb_q  <= clamp62(sa_q + t5_d);
    t7_dd <= t7_d;
    sum_q <= clamp62(sb_q + t7_dd);
  end

  // Correction magnitude and pass-through decision.
  logic [61:0] ad_q;
  flag_t       fl_q [T_AD:T_Q];

  always_ff @(posedge clk) begin
    ad_q <= sum_q[63] ? 62'(-sum_q) : sum_q[61:0];
    fl_q[T_AD].unch <= (r_q[T_SUM] == '0) || (sum_q == '0);
    fl_q[T_AD].neg  <= sum_q[63];
    for (int k = T_AD + 1; k <= T_Q; k++) fl_q[k] <= fl_q[k-1];
  end

  // Shift along each axis: |d| * |offset| / r.
  logic [127:0]     nx_w, ny_w;
  logic [QBITS-1:0] qx_w, qy_w;

  rlu_mul u_mul_nx (
    .clk (clk), .a ({32'b0, ax_q[T_AD]}), .b ({2'b0, ad_q}), .p (nx_w)
  );
  rlu_mul u_mul_ny (
    .clk (clk), .a ({32'b0, ay_q[T_AD]}), .b ({2'b0, ad_q}), .p (ny_w)
  );

  rlu_div u_div_x (
    .clk (clk), .num (nx_w[93:0]), .den (r_q[T_NUM]), .quo (qx_w)
  );
  rlu_div u_div_y (
    .clk (clk), .num (ny_w[93:0]), .den (r_q[T_NUM]), .quo (qy_w)
  );

  // Output stage.
  side_t              sd;
  flag_t              fl;
  logic signed [65:0] sx, sy, ox, oy;

  assign sd = side_q[T_Q];
  assign fl = fl_q[T_Q];
  assign sx = (sd.dx[31] != fl.neg) ? -$signed(66'(qx_w)) : $signed(66'(qx_w));
  assign sy = (sd.dy[31] != fl.neg) ? -$signed(66'(qy_w)) : $signed(66'(qy_w));
  assign ox = 66'(center_x) + 66'(sd.dx) - sx;
  assign oy = 66'(center_y) + 66'(sd.dy) - sy;

  always_ff @(posedge clk) begin
    if (fl.unch) begin
      result.out_x <= sd.pt.in_x;
      result.out_y <= sd.pt.in_y;
    end else begin
      result.out_x <= clamp32(ox);
      result.out_y <= clamp32(oy);
    end
    result.unchanged <= fl.unch;
  end

  assign done = v_q[T_OUT];

endmodule

@@ src/rlu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radial lens undistort checker
// Port-level checks on result timing and the pass-through path.
// ----------------------------------------------------------------------------
module rlu_checker
  import rlu_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input in_t  point,
  input logic done,
  input out_t result
);

  // No result leaves right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // Every result traces back to a beat accepted a fixed latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching input beat");

  // A pass-through result carries the input point unmodified.
  a_pass_x: assert property (@(posedge clk) disable iff (rst)
    done && result.unchanged |-> result.out_x == $past(point.in_x, LATENCY))
    else $error("pass-through x differs from input");

  a_pass_y: assert property (@(posedge clk) disable iff (rst)
    done && result.unchanged |-> result.out_y == $past(point.in_y, LATENCY))
    else $error("pass-through y differs from input");

endmodule

bind radial_lens_undistort rlu_checker u_rlu_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .point  (point),
  .done   (done),
  .result (result)
);
